@@ design/llmac_pkg.sv @@
// Shared types and constants for the quantised fully connected layer.
// Used by the activation store, the dot-product lanes and the top level.
package llmac_pkg;

    localparam int WEIGHT_FIELDS = 4;
    localparam int WEIGHT_W      = 8;
    localparam int NIB_W         = 4;
    localparam int BYTE_W        = 8;
    localparam int WORD_W        = 2 * BYTE_W;
    localparam int ADDR_W        = 9;
    localparam int GROUP_W       = 8;
    localparam int ACC_W         = 32;
    localparam int CNT_W         = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int OFF_W         = 2;

    // Product of a signed weight and a zero-extended nibble, and the sum of all lanes.
    localparam int PROD_W = WEIGHT_W + NIB_W + 1;
    localparam int DOT_W  = PROD_W + $clog2(WEIGHT_FIELDS);

    // Item kinds on the input channel.
    localparam logic MODE_ACT    = 1'b0;
    localparam logic MODE_WEIGHT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEURON_COUNT = 1'd1;

    typedef logic [WEIGHT_FIELDS-1:0][WEIGHT_W-1:0] weight_vec_t;
    typedef logic [WEIGHT_FIELDS-1:0]               lane_mask_t;

    // Access request to the activation store.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
    } store_req_t;

endpackage

@@ design/llmac_act_store.sv @@
// Activation store: 16-bit words holding two packed bytes each, byte-wide writes
// and two registered reads of adjacent words. Depends on llmac_pkg.
module llmac_act_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                       clk,
    input  llmac_pkg::store_req_t      req,
    input  logic [AW-1:0]              rd_word,
    output logic [llmac_pkg::WORD_W-1:0] rd_data_lo,
    output logic [llmac_pkg::WORD_W-1:0] rd_data_hi
);
    import llmac_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [AW-1:0]     wr_word;
    logic [AW-1:0]     rd_word_hi;

    assign wr_word = AW'(req.wr_addr[ADDR_W-1:1]);

    // The second word wraps to zero past the end; those nibbles are masked off.
    assign rd_word_hi = (int'(rd_word) + 1 < DEPTH) ? AW'(int'(rd_word) + 1) : '0;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            if (req.wr_addr[0])
                mem[wr_word][WORD_W-1:BYTE_W] <= req.wr_data;
            else
                mem[wr_word][BYTE_W-1:0] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_lo <= mem[rd_word];
            rd_data_hi <= mem[rd_word_hi];
        end
    end

endmodule

@@ design/llmac_dot.sv @@
// Four-lane dot product of signed 8-bit weights with unsigned 4-bit activations
// picked out of an eight-nibble window. Depends on llmac_pkg.
module llmac_dot (
    input  llmac_pkg::weight_vec_t                weights,
    input  logic [2*llmac_pkg::WORD_W-1:0]        nibbles,
    input  logic [llmac_pkg::OFF_W-1:0]           offset,
    input  llmac_pkg::lane_mask_t                 mask,
    output logic signed [llmac_pkg::DOT_W-1:0]    dot_sum
);
    import llmac_pkg::*;

    always_comb
    begin
        logic [2:0]               sel;
        logic [NIB_W-1:0]         nib;
        logic signed [PROD_W-1:0] prod;
        logic signed [DOT_W-1:0]  total;
        total = '0;
        for (int l = 0; l < WEIGHT_FIELDS; l++)
        begin
            sel  = 3'(offset) + 3'(l);
            nib  = nibbles[{sel, 2'b00} +: NIB_W];
            // Lanes past the layer end or past the lane count contribute nothing.
            if (mask[l])
                prod = $signed(weights[l]) * $signed({1'b0, nib});
            else
                prod = '0;
            total = total + DOT_W'(prod);
        end
        dot_sum = total;
    end

endmodule

@@ design/linear_layer_u4_by_i8_mac.sv @@
// Quantised fully connected layer: u4 activations times i8 weights into a 32-bit sum.
// Throughput is one item per cycle unless in_stall is high.
// The pipeline is a registered store read, the lane multiply-accumulate and an output register.
// Reset clears the accumulator, the neuron counter, all valid flags and the bias enable.
// The activation store is not cleared and holds undefined data until written.
module linear_layer_u4_by_i8_mac #(
    parameter int ACT_DEPTH = 1024,
    parameter int LANES     = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // Configuration write port.
    input  logic                                   cfg_we,
    input  logic [llmac_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [llmac_pkg::CFG_DATA_W-1:0]       cfg_data,

    // Input channel.
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   mode,
    input  logic [llmac_pkg::ADDR_W-1:0]           act_addr,
    input  logic [llmac_pkg::BYTE_W-1:0]           act_byte,
    input  logic [llmac_pkg::GROUP_W-1:0]          group_index,
    input  logic signed [llmac_pkg::WEIGHT_W-1:0]  weight_0,
    input  logic signed [llmac_pkg::WEIGHT_W-1:0]  weight_1,
    input  logic signed [llmac_pkg::WEIGHT_W-1:0]  weight_2,
    input  logic signed [llmac_pkg::WEIGHT_W-1:0]  weight_3,
    input  logic signed [llmac_pkg::WEIGHT_W-1:0]  bias,
    input  logic                                   last_group,

    // Output channel.
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [llmac_pkg::ACC_W-1:0]     neuron_sum,
    output logic [llmac_pkg::CNT_W-1:0]            neuron_index,
    output logic                                   last_neuron
);
    import llmac_pkg::*;

    // Geometry of the store. Bytes past the nine-bit address range can never be
    // written, so the memory stops there. Each word holds four nibbles.
    localparam int STORE_BYTES = (ACT_DEPTH + 1) / 2;
    localparam int MEM_BYTES   = (STORE_BYTES < 512) ? STORE_BYTES : 512;
    localparam int MEM_WORDS   = (MEM_BYTES + 1) / 2;
    localparam int WORD_AW     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int EFF_LANES   = (LANES < WEIGHT_FIELDS) ? LANES : WEIGHT_FIELDS;
    // Nibble index of a lane: group number times lane count plus up to three.
    localparam int IDX_W       = GROUP_W + $clog2(LANES) + 2;

    // Configuration registers.
    logic             bias_enable_reg;
    logic [CNT_W-1:0] neuron_count_reg;

    // Handshake.
    logic in_accept;
    logic s1_advance;

    // Address generation for an incoming weight group.
    logic [IDX_W-1:0]   base;
    logic [IDX_W-3:0]   base_word;
    logic [WORD_AW-1:0] rd_word;
    lane_mask_t         mask_next;
    store_req_t         store_req;

    // Stage one: the store read is in flight, the group waits for its data.
    logic                        s1_valid_reg;
    logic                        s1_first_reg;
    logic                        s1_last_reg;
    weight_vec_t                 s1_weights_reg;
    logic signed [WEIGHT_W-1:0]  s1_bias_reg;
    logic [OFF_W-1:0]            s1_offset_reg;
    lane_mask_t                  s1_mask_reg;
    logic [WORD_W-1:0]           rd_data_lo;
    logic [WORD_W-1:0]           rd_data_hi;

    // Accumulate.
    logic signed [DOT_W-1:0]     dot_sum;
    logic signed [ACC_W-1:0]     acc_start;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [ACC_W-1:0]     acc_reg;
    logic [CNT_W-1:0]            counter_reg;
    logic [CNT_W:0]              counter_inc;
    logic                        is_last_neuron;
    logic                        emit;

    // Output register.
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [ACC_W-1:0]     out_sum_reg;
    logic [CNT_W-1:0]            out_index_reg;
    logic                        out_last_reg;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_enable_reg  <= 1'b0;
            neuron_count_reg <= CNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIAS_ENABLE:  bias_enable_reg  <= cfg_data[0];
                REG_NEURON_COUNT: neuron_count_reg <= cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    // Stage one only has to wait when it carries a sum and the output register
    // still holds an earlier sum that the far side refuses. Every other case
    // moves on, so a new item is taken while a finished sum waits.
    assign s1_advance = !(s1_valid_reg && s1_last_reg && out_valid_reg && out_stall);
    assign in_stall   = !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Store access
    // ------------------------------------------------------------------
    // A group starts at nibble group_index * LANES. Its four nibbles always lie
    // within two adjacent words, so both are read and the window is aligned
    // later by the low two bits of the base.
    assign base      = IDX_W'(group_index) * IDX_W'(LANES);
    assign base_word = base[IDX_W-1:2];
    assign rd_word   = (int'(base_word) < MEM_WORDS) ? WORD_AW'(base_word) : '0;

    always_comb
    begin
        for (int l = 0; l < WEIGHT_FIELDS; l++)
            mask_next[l] = (l < EFF_LANES) && (int'(base) + l < ACT_DEPTH);
    end

    // Activation bytes are written at acceptance, and a weight group reads the
    // store at its own acceptance, so a read in the next cycle already sees
    // the byte written just before it and no forwarding is required.
    always_comb
    begin
        store_req.wr_en   = in_accept && (mode == MODE_ACT) && (int'(act_addr) < MEM_BYTES);
        store_req.wr_addr = act_addr;
        store_req.wr_data = act_byte;
        store_req.rd_en   = in_accept && (mode == MODE_WEIGHT);
    end

    llmac_act_store #(
        .DEPTH (MEM_WORDS),
        .AW    (WORD_AW)
    ) u_store (
        .clk        (clk),
        .req        (store_req),
        .rd_word    (rd_word),
        .rd_data_lo (rd_data_lo),
        .rd_data_hi (rd_data_hi)
    );

    // ------------------------------------------------------------------
    // Stage one registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_advance)
            s1_valid_reg <= in_accept && (mode == MODE_WEIGHT);
    end

    // Payload only loads alongside a store read, so it holds with the read data.
    always_ff @(posedge clk)
    begin
        if (store_req.rd_en)
        begin
            s1_first_reg   <= (group_index == '0);
            s1_last_reg    <= last_group;
            s1_weights_reg <= {weight_3, weight_2, weight_1, weight_0};
            s1_bias_reg    <= bias;
            s1_offset_reg  <= base[OFF_W-1:0];
            s1_mask_reg    <= mask_next;
        end
    end

    // ------------------------------------------------------------------
    // Multiply-accumulate
    // ------------------------------------------------------------------
    llmac_dot u_dot (
        .weights (s1_weights_reg),
        .nibbles ({rd_data_hi, rd_data_lo}),
        .offset  (s1_offset_reg),
        .mask    (s1_mask_reg),
        .dot_sum (dot_sum)
    );

    // Group zero restarts the sum at the bias or at zero; any other group adds
    // to whatever the accumulator holds, wrapping at 32 bits.
    always_comb
    begin
        if (s1_first_reg)
            acc_start = bias_enable_reg ? ACC_W'(s1_bias_reg) : '0;
        else
            acc_start = acc_reg;
        acc_next = acc_start + ACC_W'(dot_sum);
    end

    assign emit           = s1_valid_reg && s1_advance && s1_last_reg;
    assign counter_inc    = {1'b0, counter_reg} + (CNT_W + 1)'(1);
    // A count of zero, or a counter that has run past the count, also ends the layer.
    assign is_last_neuron = (counter_inc >= {1'b0, neuron_count_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            counter_reg <= '0;
        end
        else
        begin
            if (s1_valid_reg && s1_advance)
                acc_reg <= acc_next;
            if (emit)
                counter_reg <= is_last_neuron ? '0 : counter_inc[CNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_sum_reg   <= acc_next;
            out_index_reg <= counter_reg;
            out_last_reg  <= is_last_neuron;
        end
    end

    assign out_valid    = out_valid_reg;
    assign neuron_sum   = out_sum_reg;
    assign neuron_index = out_index_reg;
    assign last_neuron  = out_last_reg;

endmodule
